// ===== rtl/core/sorted_list_engine_assert.svh =====
// ---------------------------------------------------------------------------
// Sorted list engine assertion macros
// Shared property macros for the concurrent checks in the RTL.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_ENGINE_ASSERT_SVH
`define SORTED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted list engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted list engine: next-cycle check failed");

`endif

// ===== rtl/core/sle_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted list engine package
// Types, codes and defaults shared by the engine, its cells and interfaces.
// ---------------------------------------------------------------------------
package sle_pkg;

	localparam int SLE_CAPACITY = 16;
	localparam int SLE_DATA_W   = 32;

	typedef logic signed [SLE_DATA_W-1:0] sle_data_t;

	typedef enum logic [1:0] {
		FUNC_INSERT    = 2'd0,
		FUNC_REMOVE    = 2'd1,
		FUNC_READ_ASC  = 2'd2,
		FUNC_READ_DESC = 2'd3
	} sle_func_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} sle_status_t;

	// per-cycle command broadcast to every cell
	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_INSERT = 3'd1,
		CELL_REMOVE = 3'd2,
		CELL_ROT_L  = 3'd3,
		CELL_ROT_R  = 3'd4
	} sle_cell_op_t;

	typedef struct packed {
		sle_cell_op_t op;
		sle_data_t    key;
	} sle_cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} sle_state_t;

endpackage

// ===== rtl/core/sle_cmd_if.sv =====
// ---------------------------------------------------------------------------
// Sorted list engine command channel
// valid/ready channel carrying one operation word.
// ---------------------------------------------------------------------------
interface sle_cmd_if import sle_pkg::*; ();
	logic      valid;
	logic      ready;
	logic [1:0] func;
	sle_data_t value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

// ===== rtl/core/sle_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Sorted list engine response channel
// valid/ready channel carrying one result word.
// ---------------------------------------------------------------------------
interface sle_rsp_if import sle_pkg::*; ();
	logic       valid;
	logic       ready;
	sle_data_t  item_value;
	logic       is_last;
	logic       list_empty;
	logic [1:0] status;

	modport source (output valid, output item_value, output is_last, output list_empty,
		output status, input ready);
	modport sink (input valid, input item_value, input is_last, input list_empty,
		input status, output ready);
endinterface

// ===== rtl/core/sle_cell.sv =====
// ---------------------------------------------------------------------------
// Sorted list engine cell
// Holds one list position; shifts, inserts, removes and rotates with neighbors.
// ---------------------------------------------------------------------------
module sle_cell import sle_pkg::*; (
	input  logic          clk,
	input  sle_cell_ctl_t ctl,
	input  logic          occupied,
	input  sle_data_t     left_value,
	input  sle_data_t     right_value,
	input  logic          ins_here,   // left neighbor is below key (or this is the head)
	input  logic          hit_in,     // a match exists further toward the head
	output sle_data_t     value,
	output logic          lt,
	output logic          hit_out
);

	sle_data_t value_q;
	logic      eq;

	assign lt      = occupied && (value_q < ctl.key);
	assign eq      = occupied && (value_q == ctl.key);
	assign hit_out = hit_in || eq;
	assign value   = value_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (!lt) begin
					value_q <= ins_here ? ctl.key : left_value;
				end
			end
			CELL_REMOVE: begin
				if (hit_out) begin
					value_q <= right_value;
				end
			end
			CELL_ROT_L: value_q <= right_value;
			CELL_ROT_R: value_q <= left_value;
			default: value_q <= value_q;
		endcase
	end

endmodule

// ===== rtl/core/sorted_list_engine.sv =====
// ---------------------------------------------------------------------------
// Sorted list engine
// Bounded ascending list of signed 32-bit values kept in a row of cells.
// ---------------------------------------------------------------------------
// Usage:
//  - cmd channel: one word per operation (func, value). Insert places value
//    ahead of equal entries; remove deletes the first equal entry.
//  - rsp channel: insert/remove return one status word (ok, full, not found)
//    with is_last set. Reads return one word per entry, ascending or
//    descending, is_last on the final one; an empty list gives one word with
//    list_empty set.
//  - Insert/remove: once accepted, status word valid the next cycle;
//    one per cycle while rsp keeps up.
//  - Reads: the cell row rotates through all CAPACITY positions, one per
//    cycle, so a read holds cmd off until the rotation is done and streams
//    one entry per cycle while rsp keeps up. An empty read does not rotate.
//  - The single output register decouples the sides; if rsp stalls, the
//    rotation and cmd acceptance pause until the word is taken.
//  - Reset (arst_n low) empties the list; cell contents are not cleared.
// ---------------------------------------------------------------------------
`include "sorted_list_engine_assert.svh"

module sorted_list_engine import sle_pkg::*; #(
	parameter int CAPACITY = SLE_CAPACITY
) (
	input  logic      clk,
	input  logic      arst_n,
	sle_cmd_if.sink   cmd,
	sle_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);   // entry count
	localparam int KW = $clog2(CAPACITY);       // rotation step

	sle_state_t    state_q;
	logic [CW-1:0] count_q;
	logic [KW-1:0] step_q;
	logic          desc_q;

	logic          rsp_valid_q;
	sle_data_t     item_q;
	logic          last_q;
	logic          empty_q;
	sle_status_t   status_q;

	sle_cell_ctl_t ctl;
	sle_data_t     cell_value [CAPACITY];
	logic          cell_lt    [CAPACITY];
	logic          cell_hit   [CAPACITY];
	logic          cell_occ   [CAPACITY];

	logic          out_free;
	logic          acc;
	logic          full;
	logic          found;
	logic          step_go;
	logic          emit;
	logic          emit_last;
	logic [CW-1:0] step_ext;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign acc       = cmd.valid && cmd.ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign found     = cell_hit[CAPACITY-1];
	assign step_go   = (state_q == ST_READ) && out_free;
	assign step_ext  = CW'(step_q);

	// Ascending: rotate left, head cell shows original entry step_q.
	// Descending: rotate right, tail cell shows original entry CAPACITY-1-step_q.
	always_comb begin
		if (desc_q) begin
			emit      = step_ext >= (CW'(CAPACITY) - count_q);
			emit_last = (step_q == KW'(CAPACITY - 1));
		end else begin
			emit      = step_ext < count_q;
			emit_last = (step_ext == count_q - CW'(1));
		end
	end

	// command broadcast to the cell row
	always_comb begin
		ctl.key = cmd.value;
		ctl.op  = CELL_HOLD;
		if (acc) begin
			unique case (sle_func_t'(cmd.func))
				FUNC_INSERT: ctl.op = full ? CELL_HOLD : CELL_INSERT;
				FUNC_REMOVE: ctl.op = CELL_REMOVE;
				default:     ctl.op = CELL_HOLD;
			endcase
		end else if (step_go) begin
			ctl.op = desc_q ? CELL_ROT_R : CELL_ROT_L;
		end
	end

	// cell row, closed into a ring for rotation
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam int LEFT  = (i == 0) ? CAPACITY - 1 : i - 1;
		localparam int RIGHT = (i == CAPACITY - 1) ? 0 : i + 1;

		assign cell_occ[i] = (CW'(i) < count_q);

		sle_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (cell_occ[i]),
			.left_value  (cell_value[LEFT]),
			.right_value (cell_value[RIGHT]),
			.ins_here    ((i == 0) ? 1'b1 : cell_lt[LEFT]),
			.hit_in      ((i == 0) ? 1'b0 : cell_hit[LEFT]),
			.value       (cell_value[i]),
			.lt          (cell_lt[i]),
			.hit_out     (cell_hit[i])
		);
	end

	// control: state, count, rotation step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			desc_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (sle_func_t'(cmd.func))
							FUNC_INSERT: begin
								rsp_valid_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							FUNC_REMOVE: begin
								rsp_valid_q <= 1'b1;
								if (found) begin
									count_q <= count_q - CW'(1);
								end
							end
							default: begin
								if (count_q == '0) begin
									rsp_valid_q <= 1'b1;
								end else begin
									state_q <= ST_READ;
									step_q  <= '0;
									desc_q  <= (sle_func_t'(cmd.func) == FUNC_READ_DESC);
								end
							end
						endcase
					end
				end
				ST_READ: begin
					if (out_free) begin
						rsp_valid_q <= emit;
						step_q      <= step_q + KW'(1);
						if (step_q == KW'(CAPACITY - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (acc) begin
			item_q  <= '0;
			last_q  <= 1'b1;
			empty_q <= 1'b0;
			case (sle_func_t'(cmd.func))
				FUNC_INSERT: status_q <= full ? STATUS_FULL : STATUS_OK;
				FUNC_REMOVE: status_q <= found ? STATUS_OK : STATUS_NOT_FOUND;
				default: begin
					status_q <= STATUS_OK;
					empty_q  <= 1'b1;
				end
			endcase
		end else if (step_go) begin
			item_q   <= desc_q ? cell_value[CAPACITY-1] : cell_value[0];
			last_q   <= emit_last;
			empty_q  <= 1'b0;
			status_q <= STATUS_OK;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.item_value = item_q;
	assign rsp.is_last    = last_q;
	assign rsp.list_empty = empty_q;
	assign rsp.status     = status_q;

	`SLE_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`SLE_ASSERT_IMPL(a_no_cmd_in_read, clk, arst_n, state_q == ST_READ, !cmd.ready)
	`SLE_ASSERT_NEXT(a_full_drop, clk, arst_n,
		acc && cmd.func == FUNC_INSERT && full, rsp.valid && rsp.status == STATUS_FULL)
	`SLE_ASSERT_NEXT(a_insert_grows, clk, arst_n,
		acc && cmd.func == FUNC_INSERT && !full, count_q == $past(count_q) + CW'(1))

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sorted list engine testbench
// Drives insert, remove and read words into the engine and checks every
// response word against a shadow list kept in the bench. Directed corner
// words come first, then randomized fill / drain / mixed phases. Both
// channels see random gaps, apart from one stretch with no gaps at all.
// ---------------------------------------------------------------------------
module tb_top;
	import sle_pkg::*;

	localparam int CAP         = SLE_CAPACITY;
	localparam int RANDOM_CMDS = 150;
	localparam int IDLE_PCT    = 9;
	localparam int CYCLE_LIMIT = 200000;

	localparam sle_data_t VAL_MAX = 32'sh7fff_ffff;
	localparam sle_data_t VAL_MIN = 32'sh8000_0000;

	typedef struct packed {
		sle_func_t func;
		sle_data_t value;
	} cmd_word_t;

	typedef struct packed {
		sle_data_t   item_value;
		logic        is_last;
		logic        list_empty;
		sle_status_t status;
	} rsp_word_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic calm;

	sle_cmd_if cmd_ch ();
	sle_rsp_if rsp_ch ();

	sorted_list_engine #(
		.CAPACITY(CAP)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// stimulus store and its own view of the list contents (order not kept)
	cmd_word_t pending_cmds[$];
	sle_data_t gen_vals[CAP];
	int        gen_len = 0;

	// shadow of the engine: sorted contents and the words still owed on rsp
	sle_data_t sorted_vals[CAP];
	int        sorted_len = 0;
	rsp_word_t expected_words[$];

	int cycle_cnt   = 0;
	int cmds_sent   = 0;
	int cmds_taken  = 0;
	int total_cmds  = 0;
	int err_count   = 0;
	int words_seen  = 0;
	int n_full      = 0;
	int n_not_found = 0;
	int n_empty_rd  = 0;
	int n_reads     = 0;
	int peak_len    = 0;

	// no gaps on either side while this window of words goes out
	assign calm = (cmds_sent >= 60) && (cmds_sent < 110);

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t word %0d: %s", $time, words_seen, msg);
		err_count++;
	endtask

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	task automatic queue_cmd(sle_func_t f, sle_data_t v);
		cmd_word_t w;
		int i;
		w.func  = f;
		w.value = v;
		pending_cmds.push_back(w);
		case (f)
			FUNC_INSERT: begin
				if (gen_len < CAP) begin
					gen_vals[gen_len] = v;
					gen_len++;
				end
			end
			FUNC_REMOVE: begin
				for (i = 0; i < gen_len; i++)
					if (gen_vals[i] == v)
						break;
				if (i < gen_len) begin
					gen_vals[i] = gen_vals[gen_len-1];
					gen_len--;
				end
			end
			default: ;
		endcase
	endtask

	// small values collide often, extremes now and then, rest full-range
	function automatic sle_data_t pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return sle_data_t'(int'($urandom_range(6)) - 3);
		if (r < 50) begin
			case ($urandom_range(3))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return VAL_MAX - 1;
				default: return VAL_MIN + 1;
			endcase
		end
		return sle_data_t'($urandom);
	endfunction

	// removes mostly target something that is present
	function automatic sle_data_t pick_remove_value();
		if (gen_len > 0 && $urandom_range(99) < 70)
			return gen_vals[$urandom_range(gen_len-1)];
		return pick_value();
	endfunction

	function automatic sle_func_t pick_read();
		return ($urandom_range(1) != 0) ? FUNC_READ_ASC : FUNC_READ_DESC;
	endfunction

	// ---------------------------------------------------------------------
	// Predictor: applies one accepted command word to the shadow list and
	// queues the response words it owes.
	// ---------------------------------------------------------------------
	function automatic void predict_list_op(sle_func_t f, sle_data_t v);
		rsp_word_t w;
		int pos;
		int i;
		w = '{item_value: '0, is_last: 1'b1, list_empty: 1'b0, status: STATUS_OK};
		case (f)
			FUNC_INSERT: begin
				if (sorted_len >= CAP) begin
					w.status = STATUS_FULL;
				end else begin
					// new value goes ahead of any equal entries
					pos = 0;
					while (pos < sorted_len && sorted_vals[pos] < v)
						pos++;
					for (i = sorted_len; i > pos; i--)
						sorted_vals[i] = sorted_vals[i-1];
					sorted_vals[pos] = v;
					sorted_len++;
					if (sorted_len > peak_len)
						peak_len = sorted_len;
				end
				expected_words.push_back(w);
			end
			FUNC_REMOVE: begin
				// first (lowest) equal entry goes
				pos = 0;
				while (pos < sorted_len && sorted_vals[pos] != v)
					pos++;
				if (pos >= sorted_len) begin
					w.status = STATUS_NOT_FOUND;
				end else begin
					for (i = pos; i + 1 < sorted_len; i++)
						sorted_vals[i] = sorted_vals[i+1];
					sorted_len--;
				end
				expected_words.push_back(w);
			end
			default: begin
				n_reads++;
				if (sorted_len == 0) begin
					w.list_empty = 1'b1;
					expected_words.push_back(w);
				end else begin
					for (i = 0; i < sorted_len; i++) begin
						w.item_value = (f == FUNC_READ_ASC) ? sorted_vals[i] :
							sorted_vals[sorted_len-1-i];
						w.is_last = (i == sorted_len - 1);
						expected_words.push_back(w);
					end
				end
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Driver: presents words at the falling edge, holds each until taken.
	// rsp ready is randomized at the same edge.
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		cmd_word_t w;
		if (arst_n) begin
			if (!(cmd_ch.valid && cmds_taken < cmds_sent)) begin
				if (pending_cmds.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					w = pending_cmds.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.func  <= w.func;
					cmd_ch.value <= w.value;
					cmds_sent++;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
			rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: samples both handshakes at the rising edge. Accepted commands
	// feed the predictor; accepted responses are checked in order.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_word_t e;
		cycle_cnt++;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				cmds_taken++;
				predict_list_op(sle_func_t'(cmd_ch.func), cmd_ch.value);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_words.size() == 0) begin
					report_mismatch("response word with nothing expected");
				end else begin
					e = expected_words.pop_front();
					if (rsp_ch.item_value !== e.item_value)
						report_mismatch($sformatf("item_value got %0d exp %0d",
							rsp_ch.item_value, e.item_value));
					if (rsp_ch.is_last !== e.is_last)
						report_mismatch($sformatf("is_last got %b exp %b",
							rsp_ch.is_last, e.is_last));
					if (rsp_ch.list_empty !== e.list_empty)
						report_mismatch($sformatf("list_empty got %b exp %b",
							rsp_ch.list_empty, e.list_empty));
					if (rsp_ch.status !== e.status)
						report_mismatch($sformatf("status got %0d exp %0d",
							rsp_ch.status, e.status));
					if (e.status == STATUS_FULL)
						n_full++;
					if (e.status == STATUS_NOT_FOUND)
						n_not_found++;
					if (e.list_empty)
						n_empty_rd++;
				end
				words_seen++;
			end
		end
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("timeout: %0d cycles, %0d words still expected", cycle_cnt,
			expected_words.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Stimulus and end of run
	// ---------------------------------------------------------------------
	initial begin
		int n_rand;
		int mode;
		int len;
		int k;
		int r;
		int ins_pct;
		int rem_pct;

		cmd_ch.valid = 1'b0;
		cmd_ch.func  = FUNC_INSERT;
		cmd_ch.value = '0;
		rsp_ch.ready = 1'b0;

		// directed: empty-list reads and remove, extremes, equal values,
		// absent value
		queue_cmd(FUNC_READ_ASC, sle_data_t'($urandom));
		queue_cmd(FUNC_READ_DESC, sle_data_t'($urandom));
		queue_cmd(FUNC_REMOVE, 7);
		queue_cmd(FUNC_INSERT, 0);
		queue_cmd(FUNC_INSERT, 0);
		queue_cmd(FUNC_INSERT, VAL_MAX);
		queue_cmd(FUNC_INSERT, VAL_MIN);
		queue_cmd(FUNC_INSERT, -1);
		queue_cmd(FUNC_INSERT, 1);
		queue_cmd(FUNC_READ_ASC, sle_data_t'($urandom));
		queue_cmd(FUNC_READ_DESC, sle_data_t'($urandom));
		queue_cmd(FUNC_REMOVE, 0);
		queue_cmd(FUNC_REMOVE, 12345);
		queue_cmd(FUNC_REMOVE, VAL_MIN);
		queue_cmd(FUNC_REMOVE, VAL_MAX);
		queue_cmd(FUNC_READ_ASC, sle_data_t'($urandom));
		queue_cmd(FUNC_REMOVE, VAL_MIN);

		// random: first fill to capacity and push one past it
		n_rand = 0;
		while (gen_len < CAP) begin
			queue_cmd(FUNC_INSERT, pick_value());
			n_rand++;
		end
		queue_cmd(FUNC_INSERT, pick_value());
		queue_cmd(FUNC_READ_DESC, sle_data_t'($urandom));
		queue_cmd(FUNC_READ_ASC, sle_data_t'($urandom));
		n_rand += 3;

		// then alternating fill-heavy, drain-heavy and mixed phases
		while (n_rand < RANDOM_CMDS) begin
			mode = $urandom_range(2);
			len  = $urandom_range(8, 24);
			case (mode)
				0: begin
					ins_pct = 60;
					rem_pct = 75;
				end
				1: begin
					ins_pct = 15;
					rem_pct = 80;
				end
				default: begin
					ins_pct = 25;
					rem_pct = 50;
				end
			endcase
			for (k = 0; k < len && n_rand < RANDOM_CMDS; k++) begin
				r = $urandom_range(99);
				if (r < ins_pct)
					queue_cmd(FUNC_INSERT, pick_value());
				else if (r < rem_pct)
					queue_cmd(FUNC_REMOVE, pick_remove_value());
				else
					queue_cmd(pick_read(), sle_data_t'($urandom));
				n_rand++;
			end
		end
		total_cmds = pending_cmds.size();

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		while (cmds_taken < total_cmds)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		// tail: a read may still be rotating the cell row
		repeat (CAP + 8) @(posedge clk);

		$display("Covered %0d command words (%0d reads), %0d response words checked",
			total_cmds, n_reads, words_seen);
		$display("  %0d full drops, %0d not-found removes, %0d empty reads, peak depth %0d",
			n_full, n_not_found, n_empty_rd, peak_len);
		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", err_count);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
